// ===== design/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

    // Default pool geometry
    localparam int BLOCK_BYTES_DEF = 256;
    localparam int BLOCK_COUNT_DEF = 32;

    // Stream payload widths (whole bytes)
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    // Request kinds carried in tuser
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOFREE   = 3'd2,
        ST_NOHANDLE = 3'd3,
        ST_NORUN    = 3'd4,
        ST_BAD      = 3'd5
    } t_status;

endpackage

// ===== design/first_fit_block_allocator_top.sv =====
// First-fit contiguous block allocator: block map and handle table in RAM.
//
//  channel   dir  tdata (low bit first)                              tuser
//  s_axis    in   size_bytes[15:0] handle_in[20:16] zero[23:21]      req_type
//  m_axis    out  status[2:0] handle_out[7:3] start_block[12:8]      -
//                 byte_offset[25:13] granted_bytes[39:26]
//
//  Allocate: checks, a handle-table scan, a block-map scan, one mark step per
//  granted block, then loading the result. Free: reading the handle entry,
//  one release step per block of the run, then loading the result; zero
//  size, not enough free and bad handle finish without any scan.
//  After reset a clearing pass zeroes both RAMs; no request is taken during
//  it. One request is in work at a time; the result register lets the next
//  request enter while the last result waits.
`timescale 1ns / 1ps

module first_fit_block_allocator_top #(
    parameter int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES_DEF,
    parameter int BLOCK_COUNT = ffba_pkg::BLOCK_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // size_bytes[15:0], handle_in[20:16], zero pad[23:21]
    input  logic [ffba_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type[0]
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // status[2:0], handle_out[7:3], start_block[12:8],
    // byte_offset[25:13], granted_bytes[39:26]
    output logic [ffba_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import ffba_pkg::*;

    // Widths derived from the pool geometry
    localparam int BW   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int CW   = $clog2(BLOCK_COUNT + 1);
    localparam int BBW  = $clog2(BLOCK_BYTES + 1);
    localparam int PW   = CW + BBW;
    localparam int CMPW = (PW > 16) ? PW : 16;
    localparam int OW   = BW + BBW;
    localparam int RBW  = $clog2(65535 + BLOCK_BYTES + 1);

    typedef struct packed {
        logic          used;
        logic [BW-1:0] start;
        logic [CW-1:0] len;
    } t_entry;

    typedef enum logic [9:0] {
        S_CLR    = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_CHECK  = 10'b00_0000_0100,
        S_HSCAN  = 10'b00_0000_1000,
        S_BSCAN  = 10'b00_0001_0000,
        S_MARK   = 10'b00_0010_0000,
        S_FREAD  = 10'b00_0100_0000,
        S_UNMARK = 10'b00_1000_0000,
        S_RESP   = 10'b01_0000_0000
    } t_state;

    // Memories
    logic   r_map_mem  [BLOCK_COUNT];
    t_entry r_hent_mem [BLOCK_COUNT];
    logic   r_map_rd;
    t_entry r_hent_rd;

    // Control and working registers
    t_state          r_state;
    logic [CW-1:0]   r_addr;
    logic [CW-1:0]   r_cnt;
    logic            r_chk;
    logic [15:0]     r_size;
    logic [BW-1:0]   r_hidx;
    logic [4:0]      r_hout;
    logic [BW-1:0]   r_start;
    logic [CW-1:0]   r_len;
    t_status         r_status;
    logic [CW-1:0]   r_used_blk;
    logic [CW-1:0]   r_run_len;
    logic [RBW-1:0]  r_run_bytes;
    logic            r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Combinational helpers
    logic            s_xfer;
    logic [15:0]     s_size;
    logic [4:0]      s_hin;
    logic            s_hin_ok;
    logic [BW-1:0]   s_hin_idx;
    logic [CW-1:0]   free_blk;
    logic [PW-1:0]   free_bytes;
    logic [CW-1:0]   addr_prev;
    logic [CW-1:0]   run_len_nx;
    logic [RBW-1:0]  run_bytes_nx;
    logic            run_hit;
    logic            last_step;
    logic [OW-1:0]   offset_full;
    logic [PW-1:0]   granted_full;

    logic            map_we;
    logic            map_wdata;
    logic [BW-1:0]   hent_raddr;
    logic            hent_we;
    logic [BW-1:0]   hent_waddr;
    t_entry          hent_wdata;

    assign s_xfer    = i_s_axis_tvalid && o_s_axis_tready;
    assign s_size    = i_s_axis_tdata[15:0];
    assign s_hin     = i_s_axis_tdata[20:16];
    assign s_hin_ok  = (32'(s_hin) < 32'(BLOCK_COUNT));
    assign s_hin_idx = BW'(s_hin);

    // Free-space check: one multiply, then compare
    assign free_blk   = CW'(BLOCK_COUNT) - r_used_blk;
    assign free_bytes = PW'(free_blk) * PW'(BLOCK_BYTES);

    // Scan helpers: the data read last cycle belongs to r_addr - 1
    assign addr_prev    = r_addr - 1'b1;
    assign run_len_nx   = r_run_len + 1'b1;
    assign run_bytes_nx = r_run_bytes + RBW'(BLOCK_BYTES);
    assign run_hit      = (run_bytes_nx >= RBW'(r_size));
    assign last_step    = (r_cnt == (r_len - 1'b1));

    // Result byte figures
    assign offset_full  = OW'(r_start) * OW'(BLOCK_BYTES);
    assign granted_full = PW'(r_len) * PW'(BLOCK_BYTES);

    // Memory port control
    always_comb begin
        map_we     = (r_state == S_CLR) || (r_state == S_MARK) || (r_state == S_UNMARK);
        map_wdata  = (r_state == S_MARK);
        hent_raddr = (r_state == S_IDLE) ? s_hin_idx : r_addr[BW-1:0];
        hent_we    = 1'b0;
        hent_waddr = r_hidx;
        hent_wdata = '0;
        unique case (r_state)
            S_CLR: begin
                hent_we    = 1'b1;
                hent_waddr = r_addr[BW-1:0];
            end
            S_FREAD: begin
                hent_we          = r_hent_rd.used;
                hent_wdata.start = r_hent_rd.start;
                hent_wdata.len   = r_hent_rd.len;
            end
            S_MARK: begin
                hent_we    = last_step;
                hent_wdata = '{used: 1'b1, start: r_start, len: r_len};
            end
            default: begin
            end
        endcase
    end

    // Block map RAM
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[r_addr[BW-1:0]] <= map_wdata;
        end
        r_map_rd <= r_map_mem[r_addr[BW-1:0]];
    end

    // Handle table RAM
    always_ff @(posedge i_clk) begin
        if (hent_we) begin
            r_hent_mem[hent_waddr] <= hent_wdata;
        end
        r_hent_rd <= r_hent_mem[hent_raddr];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_used_blk  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_RESP reloads the result register itself
            if (r_out_valid && i_m_axis_tready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                // Zero both RAMs, one entry a cycle
                S_CLR: begin
                    if (r_addr == CW'(BLOCK_COUNT - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                // Take a request and sort out the quick cases
                S_IDLE: begin
                    if (s_xfer) begin
                        r_size  <= s_size;
                        r_hidx  <= s_hin_idx;
                        r_start <= '0;
                        r_len   <= '0;
                        if (i_s_axis_tuser == REQ_FREE) begin
                            r_hout <= s_hin;
                            if (s_hin_ok) begin
                                r_status <= ST_OK;
                                r_state  <= S_FREAD;
                            end else begin
                                r_status <= ST_BAD;
                                r_state  <= S_RESP;
                            end
                        end else begin
                            r_hout <= '0;
                            if (s_size == '0) begin
                                r_status <= ST_ZERO;
                                r_state  <= S_RESP;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_CHECK;
                            end
                        end
                    end
                end
                // Enough free bytes overall?
                S_CHECK: begin
                    if (CMPW'(r_size) > CMPW'(free_bytes)) begin
                        r_status <= ST_NOFREE;
                        r_state  <= S_RESP;
                    end else begin
                        r_addr  <= '0;
                        r_chk   <= 1'b0;
                        r_state <= S_HSCAN;
                    end
                end
                // Lowest unused handle
                S_HSCAN: begin
                    if (r_chk && !r_hent_rd.used) begin
                        r_hidx      <= addr_prev[BW-1:0];
                        r_hout      <= 5'(addr_prev);
                        r_addr      <= '0;
                        r_chk       <= 1'b0;
                        r_run_len   <= '0;
                        r_run_bytes <= '0;
                        r_state     <= S_BSCAN;
                    end else if (r_addr == CW'(BLOCK_COUNT)) begin
                        r_status <= ST_NOHANDLE;
                        r_state  <= S_RESP;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                        r_chk  <= 1'b1;
                    end
                end
                // First run of free blocks long enough for the request
                S_BSCAN: begin
                    if (r_chk && !r_map_rd && run_hit) begin
                        r_start <= BW'(r_addr - run_len_nx);
                        r_len   <= run_len_nx;
                        r_addr  <= r_addr - run_len_nx;
                        r_cnt   <= '0;
                        r_state <= S_MARK;
                    end else if (r_addr == CW'(BLOCK_COUNT)) begin
                        r_status <= ST_NORUN;
                        r_hout   <= '0;
                        r_state  <= S_RESP;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                        r_chk  <= 1'b1;
                        if (r_chk) begin
                            if (r_map_rd) begin
                                r_run_len   <= '0;
                                r_run_bytes <= '0;
                            end else begin
                                r_run_len   <= run_len_nx;
                                r_run_bytes <= run_bytes_nx;
                            end
                        end
                    end
                end
                // Mark the granted run used; table entry goes in on the last block
                S_MARK: begin
                    r_addr <= r_addr + 1'b1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (last_step) begin
                        r_used_blk <= r_used_blk + r_len;
                        r_state    <= S_RESP;
                    end
                end
                // Handle entry read back; a used table entry is marked unused here
                S_FREAD: begin
                    if (r_hent_rd.used) begin
                        r_start <= r_hent_rd.start;
                        r_len   <= r_hent_rd.len;
                        r_addr  <= CW'(r_hent_rd.start);
                        r_cnt   <= '0;
                        r_state <= S_UNMARK;
                    end else begin
                        r_status <= ST_BAD;
                        r_state  <= S_RESP;
                    end
                end
                // Release the run, one block a cycle
                S_UNMARK: begin
                    r_addr <= r_addr + 1'b1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (last_step) begin
                        r_used_blk <= r_used_blk - r_len;
                        r_state    <= S_RESP;
                    end
                end
                // Load the result register once it is free
                S_RESP: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {14'(granted_full), 13'(offset_full),
                                        5'(r_start), r_hout, r_status};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== design/ffba_checker.sv =====
// Port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps

module ffba_sva_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            i_s_axis_tready,
    input logic                            i_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [ffba_pkg::OUT_DATA_W-1:0] i_m_axis_tdata
);
    import ffba_pkg::*;

    logic [2:0] out_status;
    logic       fail_alloc;

    assign out_status = i_m_axis_tdata[2:0];
    assign fail_alloc = (out_status == ST_ZERO) || (out_status == ST_NOFREE) ||
                        (out_status == ST_NOHANDLE) || (out_status == ST_NORUN);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata))
        else $error("result changed while stalled");

    // One request in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && i_s_axis_tready |=> !i_s_axis_tready)
        else $error("request taken while another is in work");

    // Failed allocate reports nothing else
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && fail_alloc |-> i_m_axis_tdata[39:3] == '0)
        else $error("failed allocate with nonzero fields");

    // Bad free reports no run
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && out_status == ST_BAD |-> i_m_axis_tdata[39:8] == '0)
        else $error("bad free with nonzero run fields");

    // A good result with an empty run must sit at byte offset zero
    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && out_status == ST_OK |-> i_m_axis_tdata[39:26] != '0 ||
            i_m_axis_tdata[25:13] == '0)
        else $error("good result with empty run at nonzero offset");

endmodule

bind first_fit_block_allocator_top ffba_sva_checker u_ffba_sva_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

// ===== tb/ffba_checker.sv =====
// Scoreboard for the allocator: shadows the block map and handle table and checks each result.
`timescale 1ns / 1ps

module ffba_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    // size_bytes[15:0], handle_in[20:16], zero pad[23:21]
    input  logic [ffba_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type[0]
    input  logic                            i_s_axis_tuser,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // status[2:0], handle_out[7:3], start_block[12:8],
    // byte_offset[25:13], granted_bytes[39:26]
    input  logic [ffba_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output logic [31:0]                     o_live_handles,
    output int                              o_result_count,
    output logic [5:0]                      o_status_seen
);
    import ffba_pkg::*;

    localparam int NBLK   = BLOCK_COUNT_DEF;
    localparam int BBYTES = BLOCK_BYTES_DEF;

    typedef struct packed {
        t_status     status;
        logic [4:0]  handle;
        logic [4:0]  start_blk;
        logic [12:0] offset;
        logic [13:0] granted;
    } grant_t;

    // Shadow allocator state
    logic [NBLK-1:0] blk_busy;
    logic [NBLK-1:0] slot_live;
    int unsigned     slot_start [NBLK];
    int unsigned     slot_len   [NBLK];
    int              blocks_in_use;

    grant_t grants_due [$];
    int     fails;
    int     results;
    logic [5:0] seen;

    function automatic grant_t make_grant(t_status st, int unsigned h, int unsigned sb,
                                          int unsigned len);
        grant_t g;
        g.status    = st;
        g.handle    = h[4:0];
        g.start_blk = sb[4:0];
        g.offset    = 13'(sb * BBYTES);
        g.granted   = 14'(len * BBYTES);
        return g;
    endfunction

    // Applies one request to the shadow state and returns the grant it yields
    function automatic grant_t apply_request(logic kind, logic [15:0] size, logic [4:0] hin);
        int unsigned want;
        int unsigned h;
        int unsigned s;
        int unsigned k;
        bit          fits;
        if (kind == REQ_FREE) begin
            if (!slot_live[hin])
                return make_grant(ST_BAD, hin, 0, 0);
            for (k = 0; k < slot_len[hin]; k++) begin
                if (blk_busy[slot_start[hin] + k]) begin
                    blk_busy[slot_start[hin] + k] = 1'b0;
                    blocks_in_use--;
                end
            end
            slot_live[hin] = 1'b0;
            return make_grant(ST_OK, hin, slot_start[hin], slot_len[hin]);
        end
        if (size == 16'd0)
            return make_grant(ST_ZERO, 0, 0, 0);
        if (int'(size) > (NBLK - blocks_in_use) * BBYTES)
            return make_grant(ST_NOFREE, 0, 0, 0);
        h = NBLK;
        for (k = 0; k < NBLK; k++) begin
            if (!slot_live[k]) begin
                h = k;
                break;
            end
        end
        if (h == NBLK)
            return make_grant(ST_NOHANDLE, 0, 0, 0);
        want = (int'(size) + BBYTES - 1) / BBYTES;
        // first fit from block zero upward
        for (s = 0; s + want <= NBLK; s++) begin
            fits = 1'b1;
            for (k = 0; k < want; k++)
                if (blk_busy[s + k]) fits = 1'b0;
            if (fits) begin
                for (k = 0; k < want; k++)
                    blk_busy[s + k] = 1'b1;
                slot_live[h]  = 1'b1;
                slot_start[h] = s;
                slot_len[h]   = want;
                blocks_in_use += int'(want);
                return make_grant(ST_OK, h, s, want);
            end
        end
        return make_grant(ST_NORUN, 0, 0, 0);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    initial begin
        fails   = 0;
        results = 0;
        seen    = '0;
    end

    // Watch both channels on every rising edge
    always @(posedge i_clk) begin : watch
        grant_t exp_g;
        if (!i_rst_n) begin
            blk_busy      = '0;
            slot_live     = '0;
            blocks_in_use = 0;
            foreach (slot_start[i]) begin
                slot_start[i] = 0;
                slot_len[i]   = 0;
            end
            grants_due.delete();
        end else begin
            // result transfer: compare against the oldest outstanding grant
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                results++;
                if (grants_due.size() == 0) begin
                    $error("result with no request outstanding: tdata %h", i_m_axis_tdata);
                    fails++;
                end else begin
                    exp_g = grants_due.pop_front();
                    seen[exp_g.status] = 1'b1;
                    check_field("status", exp_g.status, i_m_axis_tdata[2:0]);
                    check_field("handle_out", exp_g.handle, i_m_axis_tdata[7:3]);
                    check_field("start_block", exp_g.start_blk, i_m_axis_tdata[12:8]);
                    check_field("byte_offset", exp_g.offset, i_m_axis_tdata[25:13]);
                    check_field("granted_bytes", exp_g.granted, i_m_axis_tdata[39:26]);
                end
            end
            // request transfer: predict its grant
            if (i_s_axis_tvalid && i_s_axis_tready)
                grants_due.push_back(apply_request(i_s_axis_tuser, i_s_axis_tdata[15:0],
                                                   i_s_axis_tdata[20:16]));
        end
        o_fail_count   <= fails;
        o_pending      <= grants_due.size();
        o_live_handles <= slot_live;
        o_result_count <= results;
        o_status_seen  <= seen;
    end

endmodule

// ===== tb/tb_first_fit_block_allocator_top.sv =====
// Testbench top for the allocator: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_top;
    import ffba_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // size_bytes[15:0], handle_in[20:16], zero pad[23:21]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // req_type[0]
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // status[2:0], handle_out[7:3], start_block[12:8],
    // byte_offset[25:13], granted_bytes[39:26]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int          fail_count;
    int          pending;
    logic [31:0] live_handles;
    int          result_count;
    logic [5:0]  status_seen;

    int unsigned sent      = 0;
    bit          send_calm = 1'b0;

    first_fit_block_allocator_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata)
    );

    ffba_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_live_handles  (live_handles),
        .o_result_count  (result_count),
        .o_status_seen   (status_seen)
    );

    // 50 MHz clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Offer one request after a random gap and hold it until the transfer
    task automatic send_request(logic kind, logic [15:0] size, logic [4:0] hnd);
        int unsigned gap;
        gap = send_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, hnd, size};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Stop offering until every outstanding grant has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly alloc/free traffic on live handles, some noise across the full field ranges
    task automatic random_request();
        int unsigned live_n;
        int unsigned roll;
        logic [4:0]  h;
        logic [15:0] sz;
        live_n = $countones(live_handles);
        roll   = $urandom_range(0, 99);
        if (roll < 6) begin
            send_request(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                         5'($urandom_range(0, 31)));
        end else if (live_n != 0 && $urandom_range(0, 23) < live_n) begin
            h = 5'($urandom_range(0, 31));
            while (!live_handles[h]) h = h + 5'd1;
            send_request(REQ_FREE, 16'($urandom_range(0, 65535)), h);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                sz = 16'($urandom_range(1, 1024));
            else if (roll < 85)
                sz = 16'(256 * $urandom_range(1, 8) + $urandom_range(0, 2) - 1);
            else
                sz = 16'($urandom_range(1, 8192));
            send_request(REQ_ALLOC, sz, 5'($urandom_range(0, 31)));
        end
    endtask

    // Request side: reset, directed cases, then random phases
    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero size, rounding, oversize request, double free and never-used handle
        send_request(REQ_ALLOC, 16'd0, 5'd31);
        send_request(REQ_ALLOC, 16'd1, 5'd0);
        send_request(REQ_ALLOC, 16'd256, 5'd17);
        send_request(REQ_ALLOC, 16'd257, 5'd0);
        send_request(REQ_ALLOC, 16'hFFFF, 5'd31);
        send_request(REQ_FREE, 16'hFFFF, 5'd1);
        send_request(REQ_FREE, 16'd0, 5'd1);
        send_request(REQ_FREE, 16'h5A5A, 5'd31);
        // first fit skips the one-block hole, then a small grant fills it
        send_request(REQ_ALLOC, 16'd512, 5'd0);
        send_request(REQ_ALLOC, 16'd200, 5'd0);
        for (n = 0; n < 4; n++)
            send_request(REQ_FREE, 16'd0, 5'(n));
        // whole pool in one grant
        send_request(REQ_ALLOC, 16'd8192, 5'd0);
        send_request(REQ_FREE, 16'd0, 5'd0);
        // fragment the pool so enough bytes are free but no run is long enough
        for (n = 0; n < 4; n++)
            send_request(REQ_ALLOC, 16'd2048, 5'd0);
        send_request(REQ_FREE, 16'd0, 5'd0);
        send_request(REQ_FREE, 16'd0, 5'd2);
        send_request(REQ_ALLOC, 16'd2049, 5'd0);
        send_request(REQ_FREE, 16'd0, 5'd1);
        send_request(REQ_FREE, 16'd0, 5'd3);
        // no-handle status cannot occur: every grant takes at least one of
        // BLOCK_COUNT blocks, so handles never run out first

        for (phase = 0; phase < 10; phase++) begin
            if (phase % 2 == 1)
                drain_results();
            send_calm = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 103; n++)
                random_request();
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (150) @(posedge i_clk);
        $display("%0d requests sent, %0d results checked", sent, result_count);
        $display("status codes returned (bit per code, 5 down to 0): %b", status_seen);
        if (fail_count == 0 && pending == 0)
            $display("tb_first_fit_block_allocator_top passed");
        else
            $display("tb_first_fit_block_allocator_top failed");
        $finish;
    end

    // Result side: random stalls, calm stretches and one long hold-off
    initial begin : sink
        int unsigned stall;
        int unsigned taken;
        bit          calm;
        taken = 0;
        calm  = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (taken % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 19);
            if (taken == 300)
                stall = 400;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    // Hang guard
    initial begin
        #15_000_000;
        $display("tb_first_fit_block_allocator_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/ffba_pkg.sv
design/first_fit_block_allocator_top.sv
design/ffba_checker.sv
tb/ffba_checker.sv
tb/tb_first_fit_block_allocator_top.sv
